/* rtl/pngw_pkg.sv */
package pngw_pkg;

    // Frame buffer geometry in pixels.
    localparam int FB_WIDTH  = 64;
    localparam int FB_HEIGHT = 64;

    // Field widths of the streams.
    localparam int COORD_W  = 10;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 12;
    localparam int COLOR_W  = 16;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 32;

    // Palette store: one 24-bit entry per index value.
    localparam int PAL_DEPTH = 256;
    localparam int PAL_W     = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd3;

    // Pixel format codes; codes above FMT_INDEXED are unsupported.
    localparam logic [2:0] FMT_GRAY    = 3'd0;
    localparam logic [2:0] FMT_RGB     = 3'd1;
    localparam logic [2:0] FMT_RGBA    = 3'd2;
    localparam logic [2:0] FMT_INDEXED = 3'd3;

    // Item kinds carried on tuser.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_NONE = 16'h0000;

    // Truncate three 8-bit channels to RGB565.
    function automatic logic [COLOR_W-1:0] to565(
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] g,
        input logic [BYTE_W-1:0] b
    );
        to565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

/* rtl/pngw_ram.sv */
module pngw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/png_scanline_to_rgb565_writer_unit.sv */
// Channel   Direction  Content
// s_axis    in         tuser: kind; tdata: row, column, line_width, byte_first,
//                      byte_second, byte_third, alpha_byte, entry
// m_axis    out        tdata: fb_address, color
// cfg       in         write enable, register index, write data
//
// A pixel passes two register stages: the input stage, where the palette read
// is issued, and the result register, from which its write is offered. One
// item is taken every cycle while results are taken; the palette memory port
// does a write or a read for each item. Reset is synchronous and active low;
// it clears the stage flags, the palette-loaded flag and the configuration
// registers, but not the palette. A stall on the result side holds the result
// register, and tready falls once the input stage also holds an item.
module png_scanline_to_rgb565_writer_unit
    import pngw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // Bits from 0: row[9:0], column[19:10], line_width[29:20],
    // byte_first[37:30], byte_second[45:38], byte_third[53:46],
    // alpha_byte[61:54], entry[69:62], zero fill [71:70].
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // Bit 0: kind.
    input  logic                  i_s_axis_tuser,
    // Result stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // Bits from 0: fb_address[11:0], color[27:12], zero fill [31:28].
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RAM_AW = $clog2(PAL_DEPTH);
    localparam int PROD_W = 24;

    // Unpacked input fields.
    logic [COORD_W-1:0] in_row, in_column, in_line_width;
    logic [BYTE_W-1:0]  in_b0, in_b1, in_b2, in_alpha, in_entry;

    assign in_row        = i_s_axis_tdata[9:0];
    assign in_column     = i_s_axis_tdata[19:10];
    assign in_line_width = i_s_axis_tdata[29:20];
    assign in_b0         = i_s_axis_tdata[37:30];
    assign in_b1         = i_s_axis_tdata[45:38];
    assign in_b2         = i_s_axis_tdata[53:46];
    assign in_alpha      = i_s_axis_tdata[61:54];
    assign in_entry      = i_s_axis_tdata[69:62];

    // Configuration registers.
    logic [2:0]         r_pixel_format;
    logic [7:0]         r_offset_x, r_offset_y;
    logic [COORD_W-1:0] r_image_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_RGB;
            r_offset_x     <= '0;
            r_offset_y     <= '0;
            r_image_width  <= COORD_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[2:0];
                REG_OFFSET_X:     r_offset_x     <= i_cfg_data[7:0];
                REG_OFFSET_Y:     r_offset_y     <= i_cfg_data[7:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees when empty or taken, and the
    // input stage moves whenever the result register can load.
    logic r_s1_valid, r_out_valid, r_pal_loaded;
    logic out_free, s_xfer;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    // Palette memory: palette items write, pixels read at their index.
    logic             pal_we, pal_re;
    logic [PAL_W-1:0] pal_rdata;

    assign pal_we = s_xfer && (i_s_axis_tuser == KIND_PALETTE);
    assign pal_re = s_xfer && (i_s_axis_tuser == KIND_PIXEL);

    pngw_ram #(
        .WIDTH(PAL_W),
        .DEPTH(PAL_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (pal_we),
        .i_waddr(in_entry[RAM_AW-1:0]),
        .i_wdata({in_b0, in_b1, in_b2}),
        .i_re   (pal_re),
        .i_raddr(in_b0[RAM_AW-1:0]),
        .o_rdata(pal_rdata)
    );

    // Input stage registers.
    logic [COORD_W-1:0] r_s1_row, r_s1_column, r_s1_line_width;
    logic [BYTE_W-1:0]  r_s1_b0, r_s1_b1, r_s1_b2, r_s1_alpha;
    logic               r_s1_loaded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_pal_loaded <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_s1_valid <= pal_re;
            end
            if (pal_we) begin
                r_pal_loaded <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_re) begin
            r_s1_row        <= in_row;
            r_s1_column     <= in_column;
            r_s1_line_width <= in_line_width;
            r_s1_b0         <= in_b0;
            r_s1_b1         <= in_b1;
            r_s1_b2         <= in_b2;
            r_s1_alpha      <= in_alpha;
            r_s1_loaded     <= r_pal_loaded;
        end
    end

    // Placement: signed frame coordinates and the column limit.
    logic signed [11:0]  dy, dx;
    logic [COORD_W-1:0]  limit_a, limit;
    logic                row_ok, col_ok, fmt_ok;
    logic [PROD_W-1:0]   addr_full;

    assign dy = $signed({2'b00, r_s1_row}) + 12'(signed'(r_offset_y));
    assign dx = $signed({2'b00, r_s1_column}) + 12'(signed'(r_offset_x));

    assign limit_a = (r_image_width < COORD_W'(FB_WIDTH)) ? r_image_width
                                                          : COORD_W'(FB_WIDTH);
    assign limit   = (r_s1_line_width < limit_a) ? r_s1_line_width : limit_a;

    assign row_ok = !dy[11] && (dy < 12'(FB_HEIGHT));
    assign col_ok = (r_s1_column < limit) && !dx[11] && (dx < 12'(FB_WIDTH));
    assign fmt_ok = !r_pixel_format[2];

    assign addr_full = PROD_W'(unsigned'(dy)) * PROD_W'(FB_WIDTH)
                     + PROD_W'(unsigned'(dx));

    // Colour selection by pixel format.
    logic [COLOR_W-1:0] n_out_color;

    always_comb begin
        case (r_pixel_format)
            FMT_GRAY:    n_out_color = to565(r_s1_b0, r_s1_b0, r_s1_b0);
            FMT_RGB:     n_out_color = to565(r_s1_b0, r_s1_b1, r_s1_b2);
            FMT_RGBA:    n_out_color = (r_s1_alpha == '0) ? COLOR_NONE
                                     : to565(r_s1_b0, r_s1_b1, r_s1_b2);
            FMT_INDEXED: n_out_color = r_s1_loaded
                                     ? to565(pal_rdata[23:16], pal_rdata[15:8],
                                             pal_rdata[7:0])
                                     : COLOR_NONE;
            default:     n_out_color = COLOR_NONE;
        endcase
    end

    logic n_out_valid;
    assign n_out_valid = r_s1_valid && fmt_ok && row_ok && col_ok;

    // Result register.
    logic [ADDR_W-1:0]  r_out_addr;
    logic [COLOR_W-1:0] r_out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && n_out_valid) begin
            r_out_addr  <= addr_full[ADDR_W-1:0];
            r_out_color <= n_out_color;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_color, r_out_addr};

    // A palette transfer marks the palette as loaded from then on.
    a_pal_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_we |=> r_pal_loaded)
        else $error("palette flag not set after a palette transfer");

    // Input is refused only while both stages hold an item.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_out_valid && !i_m_axis_tready))
        else $error("input refused without a full pipeline");

    // A stalled input stage keeps its item.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> r_s1_valid)
        else $error("input stage item lost during a stall");

    // A palette transfer never loads the input stage.
    a_pal_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_we |=> !r_s1_valid)
        else $error("palette transfer entered the pixel path");

endmodule
